/* rtl/srr_pkg.sv */
// shared constants and types for the selective-repeat receiver
`default_nettype none

package srr_pkg;

  // receive window and slot store sizing (SLOTS must be a power of two)
  localparam int WINDOW       = 4;
  localparam int SLOTS        = 8;
  localparam int PAYLOAD_BITS = 64;

  // fixed field widths
  localparam int SEQ_W  = 32;
  localparam int WORD_W = 64;

  // derived widths
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);

  // request queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // result kinds
  localparam logic KIND_ACK     = 1'b0;
  localparam logic KIND_DELIVER = 1'b1;

  // one good request as classified by the front
  typedef struct packed {
    logic [SEQ_W-1:0]        seq;
    logic [SEQ_W:0]          seq_plus_win;
    logic [SLOT_W-1:0]       slot;
    logic [PAYLOAD_BITS-1:0] word;
  } pkt_t;

  // queue status seen by the producer and consumer
  typedef struct packed {
    logic full;
    logic nonempty;
  } q_status_t;

  // back end sequencer states
  typedef enum logic {
    B_IDLE,
    B_DELIVER
  } back_state_t;

endpackage

`default_nettype wire

/* rtl/srr_front.sv */
// front end: accepts requests, drops corrupt ones, precomputes slot and window top
`default_nettype none

module srr_front
  import srr_pkg::*;
(
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_checksum_ok,
  input  wire logic [SEQ_W-1:0]  in_seq_num,
  input  wire logic [WORD_W-1:0] in_payload_word,
  input  wire q_status_t         q_status,
  output logic                   q_push,
  output pkt_t                   q_pkt
);

  // hold off while the queue has no room
  assign in_stall = q_status.full;

  // only good requests go on to the back end
  assign q_push = in_valid && !q_status.full && in_checksum_ok;

  // classify fields for the back end
  always_comb begin
    q_pkt.seq          = in_seq_num;
    q_pkt.seq_plus_win = {1'b0, in_seq_num} + (SEQ_W + 1)'(WINDOW);
    q_pkt.slot         = in_seq_num[SLOT_W-1:0];
    q_pkt.word         = in_payload_word[PAYLOAD_BITS-1:0];
  end

endmodule

`default_nettype wire

/* rtl/srr_queue.sv */
// short request queue between front and back end
`default_nettype none

module srr_queue
  import srr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire pkt_t push_pkt,
  input  wire logic pop,
  output pkt_t      head_pkt,
  output q_status_t status
);

  pkt_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign do_push = push && (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign do_pop  = pop && (cnt_r != '0);

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(rd_ptr_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = QCNT_W'(cnt_r + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = QCNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_pkt;
    end
  end

  assign head_pkt        = mem_r[rd_ptr_r];
  assign status.full     = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign status.nonempty = (cnt_r != '0);

endmodule

`default_nettype wire

/* rtl/srr_back.sv */
// back end: window check, slot store, acknowledgement and in-order delivery
`default_nettype none

module srr_back
  import srr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire q_status_t         q_status,
  input  wire pkt_t              q_pkt,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_result_kind,
  output logic [SEQ_W-1:0]       out_ack_number,
  output logic [WORD_W-1:0]      out_delivered_word,
  output logic                   out_last
);

  localparam logic [SLOT_W-1:0] WIN_MOD = SLOT_W'(WINDOW % SLOTS);

  back_state_t             state_r, state_nxt;
  logic [SEQ_W-1:0]        base_r, base_nxt;
  logic [SLOTS-1:0]        filled_r, filled_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [PAYLOAD_BITS-1:0] payload_r [SLOTS];

  logic                    out_valid_r, out_valid_nxt;
  logic                    out_kind_r, out_kind_nxt;
  logic [SEQ_W-1:0]        out_ack_r, out_ack_nxt;
  logic [PAYLOAD_BITS-1:0] out_word_r, out_word_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    can_emit;
  logic                    slot_we;
  logic [SEQ_W:0]          s_ext, b_ext, b_plus_win;
  logic                    in_window, below_window, at_base;
  logic [SLOT_W-1:0]       base_slot, top_slot, next_slot;
  logic [SLOTS-1:0]        filled_clr;

  // output register may load when empty or being taken
  assign can_emit = !out_valid_r || !out_stall;

  // window classification against the current base
  always_comb begin
    s_ext        = {1'b0, q_pkt.seq};
    b_ext        = {1'b0, base_r};
    b_plus_win   = b_ext + (SEQ_W + 1)'(WINDOW);
    in_window    = (s_ext >= b_ext) && (s_ext < b_plus_win);
    below_window = (s_ext < b_ext) && (q_pkt.seq_plus_win >= b_ext);
    at_base      = (q_pkt.seq == base_r);
  end

  // slots touched by one delivery step
  always_comb begin
    base_slot  = base_r[SLOT_W-1:0];
    top_slot   = SLOT_W'(base_slot + WIN_MOD);
    next_slot  = SLOT_W'(base_slot + 1'b1);
    filled_clr = filled_r;
    filled_clr[base_slot] = 1'b0;
    filled_clr[top_slot]  = 1'b0;
  end

  // sequencer: next state and result register loading
  always_comb begin
    state_nxt     = state_r;
    base_nxt      = base_r;
    filled_nxt    = filled_r;
    cnt_nxt       = cnt_r;
    q_pop         = 1'b0;
    slot_we       = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_kind_nxt  = out_kind_r;
    out_ack_nxt   = out_ack_r;
    out_word_nxt  = out_word_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      B_IDLE: begin
        if (q_status.nonempty && can_emit) begin
          q_pop = 1'b1;
          if (in_window) begin
            slot_we                 = 1'b1;
            filled_nxt[q_pkt.slot]  = 1'b1;
            out_valid_nxt           = 1'b1;
            out_kind_nxt            = KIND_ACK;
            out_ack_nxt             = q_pkt.seq;
            out_word_nxt            = '0;
            out_last_nxt            = !at_base;
            if (at_base) begin
              cnt_nxt   = '0;
              state_nxt = B_DELIVER;
            end
          end else if (below_window) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_ACK;
            out_ack_nxt   = q_pkt.seq;
            out_word_nxt  = '0;
            out_last_nxt  = 1'b1;
          end
        end
      end
      B_DELIVER: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_DELIVER;
          out_ack_nxt   = '0;
          out_word_nxt  = payload_r[base_slot];
          out_last_nxt  = (cnt_r == CNT_W'(WINDOW - 1)) || !filled_clr[next_slot];
          filled_nxt    = filled_clr;
          base_nxt      = SEQ_W'(base_r + 1'b1);
          cnt_nxt       = CNT_W'(cnt_r + 1'b1);
          if (out_last_nxt) begin
            state_nxt = B_IDLE;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      base_r      <= '0;
      filled_r    <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      filled_r    <= filled_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload registers
  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_ack_r  <= out_ack_nxt;
    out_word_r <= out_word_nxt;
    out_last_r <= out_last_nxt;
  end

  // slot payload store
  always_ff @(posedge clk) begin
    if (slot_we) begin
      payload_r[q_pkt.slot] <= q_pkt.word;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_kind    = out_kind_r;
  assign out_ack_number     = out_ack_r;
  assign out_delivered_word = WORD_W'(out_word_r);
  assign out_last           = out_last_r;

endmodule

`default_nettype wire

/* rtl/selective_repeat_receiver_core.sv */
// Selective-repeat receiver: good requests in window are stored and acknowledged,
// in-order runs are delivered from the slot store, one result per cycle while
// out_stall is low. Acks pass through the request queue and the result register.
// The back end takes no new request while it delivers a run of up to WINDOW words;
// corrupt requests are dropped by the front.
// Reset: synchronous active-low rst_n clears base, filled flags, queue and out_valid.
`default_nettype none

module selective_repeat_receiver_core
  import srr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_checksum_ok,
  input  wire logic [SEQ_W-1:0]  in_seq_num,
  input  wire logic [WORD_W-1:0] in_payload_word,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_result_kind,
  output logic [SEQ_W-1:0]       out_ack_number,
  output logic [WORD_W-1:0]      out_delivered_word,
  output logic                   out_last
);

  q_status_t q_status;
  logic      q_push, q_pop;
  pkt_t      push_pkt, head_pkt;

  // accept and classify
  srr_front u_front (
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_checksum_ok  (in_checksum_ok),
    .in_seq_num      (in_seq_num),
    .in_payload_word (in_payload_word),
    .q_status        (q_status),
    .q_push          (q_push),
    .q_pkt           (push_pkt)
  );

  // decoupling queue
  srr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_pkt (push_pkt),
    .pop      (q_pop),
    .head_pkt (head_pkt),
    .status   (q_status)
  );

  // window handling and delivery
  srr_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_status           (q_status),
    .q_pkt              (head_pkt),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_kind    (out_result_kind),
    .out_ack_number     (out_ack_number),
    .out_delivered_word (out_delivered_word),
    .out_last           (out_last)
  );

endmodule

`default_nettype wire
